// ===== rtl/bced_pkg.sv =====
package bced_pkg;

  localparam int unsigned EV_W    = 7;
  localparam int unsigned TIMER_W = 16;
  localparam int unsigned DIV_W   = 8;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // event flag positions
  localparam int unsigned EV_HOLD   = 0;
  localparam int unsigned EV_DOWN   = 1;
  localparam int unsigned EV_UP     = 2;
  localparam int unsigned EV_SINGLE = 3;
  localparam int unsigned EV_DOUBLE = 4;
  localparam int unsigned EV_LONG   = 5;
  localparam int unsigned EV_REPEAT = 6;

  localparam logic [EV_W-1:0] EV_HOLD_ONLY = 7'h01;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_CHECK = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLARITY   = 3'd0,
    CFG_DEBOUNCE   = 3'd1,
    CFG_HOLD_LIMIT = 3'd2,
    CFG_DOUBLE_WIN = 3'd3,
    CFG_REPEAT     = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_PRESSED  = 3'd1,
    MODE_RELEASED = 3'd2,
    MODE_SECOND   = 3'd3,
    MODE_LONG     = 3'd4
  } mode_t;

  localparam logic [DIV_W-1:0]   RST_DEBOUNCE   = 8'd20;
  localparam logic [TIMER_W-1:0] RST_HOLD_LIMIT = 16'd2000;
  localparam logic [TIMER_W-1:0] RST_DOUBLE_WIN = 16'd250;
  localparam logic [TIMER_W-1:0] RST_REPEAT     = 16'd125;

  typedef struct packed {
    logic               press_low;
    logic [DIV_W-1:0]   debounce;
    logic [TIMER_W-1:0] hold_limit;
    logic [TIMER_W-1:0] double_win;
    logic [TIMER_W-1:0] repeat_ticks;
  } cfg_t;

  typedef struct packed {
    mode_t              mode;
    logic [TIMER_W-1:0] timer;
    logic [DIV_W-1:0]   div;
    logic               last;
    logic [EV_W-1:0]    events;
  } state_t;

endpackage

// ===== rtl/bced_if.sv =====
interface bced_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic       pin_level;
  logic [6:0] event_mask;

  modport source (output valid, operation, pin_level, event_mask, input ready);
  modport sink (input valid, operation, pin_level, event_mask, output ready);
endinterface

interface bced_out_if;
  logic       valid;
  logic       ready;
  logic       matched;
  logic [6:0] flags_now;
  logic       pressed;
  logic       logic_level;

  modport source (output valid, matched, flags_now, pressed, logic_level, input ready);
  modport sink (input valid, matched, flags_now, pressed, logic_level, output ready);
endinterface

// ===== rtl/bced_fsm.sv =====
module bced_fsm (
  input  bced_pkg::cfg_t   cfg,
  input  bced_pkg::state_t cur,
  input  logic             lvl,
  output bced_pkg::state_t nxt
);

  logic [bced_pkg::TIMER_W-1:0] t_dec;
  logic [bced_pkg::DIV_W-1:0]   div_inc;
  logic                         run;
  logic                         t_zero;
  bced_pkg::mode_t              mode_nxt;

  assign t_dec   = (cur.timer != '0) ? cur.timer - 1'b1 : '0;
  assign div_inc = cur.div + 1'b1;
  assign run     = (div_inc >= cfg.debounce);
  assign t_zero  = (t_dec == '0);

  // next mode
  always_comb begin
    mode_nxt = cur.mode;
    if (run) begin
      unique case (cur.mode)
        bced_pkg::MODE_IDLE: begin
          if (lvl) mode_nxt = bced_pkg::MODE_PRESSED;
        end
        bced_pkg::MODE_PRESSED: begin
          if (!lvl) mode_nxt = bced_pkg::MODE_RELEASED;
          else if (t_zero) mode_nxt = bced_pkg::MODE_LONG;
        end
        bced_pkg::MODE_RELEASED: begin
          if (lvl) mode_nxt = bced_pkg::MODE_SECOND;
          else if (t_zero) mode_nxt = bced_pkg::MODE_IDLE;
        end
        bced_pkg::MODE_SECOND: begin
          if (!lvl) mode_nxt = bced_pkg::MODE_IDLE;
        end
        bced_pkg::MODE_LONG: begin
          if (!lvl) mode_nxt = bced_pkg::MODE_IDLE;
        end
        default: mode_nxt = bced_pkg::MODE_IDLE;
      endcase
    end
  end

  // timer, divider and flags
  always_comb begin
    nxt       = cur;
    nxt.mode  = mode_nxt;
    nxt.timer = t_dec;
    nxt.div   = div_inc;
    if (run) begin
      nxt.div  = '0;
      nxt.last = lvl;
      nxt.events[bced_pkg::EV_HOLD] = lvl;
      if (lvl && !cur.last) nxt.events[bced_pkg::EV_DOWN] = 1'b1;
      if (!lvl && cur.last) nxt.events[bced_pkg::EV_UP] = 1'b1;
      unique case (cur.mode)
        bced_pkg::MODE_IDLE: begin
          if (lvl) nxt.timer = cfg.hold_limit;
        end
        bced_pkg::MODE_PRESSED: begin
          if (!lvl) begin
            nxt.timer = cfg.double_win;
          end else if (t_zero) begin
            nxt.timer = cfg.repeat_ticks;
            nxt.events[bced_pkg::EV_LONG] = 1'b1;
          end
        end
        bced_pkg::MODE_RELEASED: begin
          if (!lvl && t_zero) nxt.events[bced_pkg::EV_SINGLE] = 1'b1;
        end
        bced_pkg::MODE_SECOND: begin
          if (!lvl) nxt.events[bced_pkg::EV_DOUBLE] = 1'b1;
        end
        bced_pkg::MODE_LONG: begin
          nxt.events[bced_pkg::EV_LONG] = 1'b1;
          if (lvl && t_zero) begin
            nxt.timer = cfg.repeat_ticks;
            nxt.events[bced_pkg::EV_REPEAT] = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/button_click_event_detector_core.sv =====
// Path: an accepted item goes through the input register, then the result register.
// Throughput: one item per cycle while the result register is not stalled; a stalled
//   result register still lets one more item into the input register.
// Reset: rst_n is synchronous and active low; it empties both registers, returns the
//   machine to idle with timer, divider, last level and flags at zero, and loads the
//   timing registers with their defaults (active low, 20, 2000, 250, 125).
module button_click_event_detector_core (
  input  logic                            clk,
  input  logic                            rst_n,
  bced_in_if.sink                         in_chan,
  bced_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [bced_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bced_pkg::CFG_W-1:0]      cfg_data
);

  // Configuration registers
  bced_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_low    <= 1'b1;
      cfg_r.debounce     <= bced_pkg::RST_DEBOUNCE;
      cfg_r.hold_limit   <= bced_pkg::RST_HOLD_LIMIT;
      cfg_r.double_win   <= bced_pkg::RST_DOUBLE_WIN;
      cfg_r.repeat_ticks <= bced_pkg::RST_REPEAT;
    end else if (cfg_we) begin
      // indexes past the list are dropped
      unique case (bced_pkg::cfg_idx_t'(cfg_index))
        bced_pkg::CFG_POLARITY:   cfg_r.press_low    <= cfg_data[0];
        bced_pkg::CFG_DEBOUNCE:   cfg_r.debounce     <= cfg_data[bced_pkg::DIV_W-1:0];
        bced_pkg::CFG_HOLD_LIMIT: cfg_r.hold_limit   <= cfg_data;
        bced_pkg::CFG_DOUBLE_WIN: cfg_r.double_win   <= cfg_data;
        bced_pkg::CFG_REPEAT:     cfg_r.repeat_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: holds one item; it moves on whenever the result register can
  // take a new value, so the block can accept one more item while a result waits.
  logic                       s1_v_r;
  logic [1:0]                 s1_op_r;
  logic                       s1_pin_r;
  logic [bced_pkg::EV_W-1:0]  s1_mask_r;

  logic adv;   // result register loads this cycle
  logic proc;  // the held item is processed and retired into the result register

  assign adv            = !out_chan.valid || out_chan.ready;
  assign proc           = s1_v_r && adv;
  assign in_chan.ready  = !s1_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_op_r   <= in_chan.operation;
      s1_pin_r  <= in_chan.pin_level;
      s1_mask_r <= in_chan.event_mask;
    end
  end

  // Machine state, updated exactly once per processed item so that the next item
  // in the input register always sees the result of the one before it.
  bced_pkg::state_t st_r, st_nxt, tick_nxt;
  logic             lvl;
  logic             matched_nxt;

  assign lvl = cfg_r.press_low ? ~s1_pin_r : s1_pin_r;

  bced_fsm u_fsm (
    .cfg (cfg_r),
    .cur (st_r),
    .lvl (lvl),
    .nxt (tick_nxt)
  );

  always_comb begin
    st_nxt      = st_r;
    matched_nxt = 1'b0;
    unique case (bced_pkg::op_t'(s1_op_r))
      bced_pkg::OP_TICK: st_nxt = tick_nxt;
      bced_pkg::OP_CHECK: begin
        matched_nxt = |(st_r.events & s1_mask_r);
        // a query of the hold bit alone leaves everything set
        if (matched_nxt && s1_mask_r != bced_pkg::EV_HOLD_ONLY) begin
          st_nxt.events = st_r.events & ~s1_mask_r;
        end
      end
      bced_pkg::OP_CLEAR: st_nxt.events = '0;
      default: ;  // unused code: report flags, change nothing
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode   <= bced_pkg::MODE_IDLE;
      st_r.timer  <= '0;
      st_r.div    <= '0;
      st_r.last   <= 1'b0;
      st_r.events <= '0;
    end else if (proc) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  logic                      out_v_r;
  logic                      out_matched_r;
  logic [bced_pkg::EV_W-1:0] out_flags_r;
  logic                      out_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_matched_r <= matched_nxt;
      out_flags_r   <= st_nxt.events;
      out_level_r   <= lvl;
    end
  end

  assign out_chan.valid       = out_v_r;
  assign out_chan.matched     = out_matched_r;
  assign out_chan.flags_now   = out_flags_r;
  assign out_chan.pressed     = out_flags_r[bced_pkg::EV_HOLD];
  assign out_chan.logic_level = out_level_r;

  // Only a check item may report a match
  a_match_only_check: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && s1_op_r != bced_pkg::OP_CHECK) |=> !out_matched_r)
    else $error("match reported for a non-check item");

  // A clear item always returns an empty flag set
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && s1_op_r == bced_pkg::OP_CLEAR) |=> (out_flags_r == '0))
    else $error("clear item left flags set");

  // Leaving idle for pressed happens only with the key seen held
  a_press_sets_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.mode == bced_pkg::MODE_PRESSED && $past(st_r.mode) == bced_pkg::MODE_IDLE)
      |-> st_r.events[bced_pkg::EV_HOLD])
    else $error("pressed entered without hold flag");

  // State moves only when an item is retired
  a_state_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!proc) |=> $stable(st_r))
    else $error("state changed without an item");

  // An empty input register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_v_r) |-> in_chan.ready)
    else $error("input stalled with empty input register");

endmodule

// ===== bench/button_click_event_detector_core_test.sv =====
`timescale 1ns / 100ps

module button_click_event_detector_core_test;

  // Operation code that the block must treat as a no-op.
  localparam logic [1:0] OP_RESERVED = 2'd3;
  // Register indexes at and above this one select no register.
  localparam int unsigned CFG_IDX_USED = 5;
  localparam logic [bced_pkg::EV_W-1:0] EV_NONE = '0;
  localparam logic [bced_pkg::EV_W-1:0] EV_ALL_MASK = '1;
  localparam int unsigned MAX_REPORTS = 10;
  // Cap on one run of press or release ticks, so the slow settings stay cheap.
  localparam int RUN_CAP = 400;

  typedef struct packed {
    logic                      matched;
    logic [bced_pkg::EV_W-1:0] flags_now;
    logic                      pressed;
    logic                      logic_level;
  } click_result_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [bced_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bced_pkg::CFG_W-1:0]     cfg_data;

  bced_in_if  in_chan ();
  bced_out_if out_chan ();

  button_click_event_detector_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the detector: its registers and its state machine.
  bced_pkg::cfg_t   btn_cfg;
  bced_pkg::state_t btn_state;
  click_result_t    pending_results[$];

  int fault_count        = 0;
  int items_sent         = 0;
  int traffic_goal       = 0;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  // Cycles the receiver still has to hold off; set by the back-pressure test.
  int hold_off_left      = 0;

  // 4 ns clock: high and low phase of 2 ns each.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Predict the result of one accepted item and advance the shadow state.
  function automatic click_result_t predict_click_result(logic [1:0] op, logic pin,
                                                         logic [bced_pkg::EV_W-1:0] mask);
    click_result_t r;
    logic          lvl;
    lvl = btn_cfg.press_low ? ~pin : pin;
    r.matched = 1'b0;
    case (op)
      bced_pkg::OP_TICK: begin
        // The window timer runs on every tick; the machine only on divider wrap.
        if (btn_state.timer != '0) btn_state.timer = btn_state.timer - 1'b1;
        btn_state.div = btn_state.div + 1'b1;
        if (btn_state.div >= btn_cfg.debounce) begin
          btn_state.div = '0;
          btn_state.events[bced_pkg::EV_HOLD] = lvl;
          if (lvl && !btn_state.last) btn_state.events[bced_pkg::EV_DOWN] = 1'b1;
          if (!lvl && btn_state.last) btn_state.events[bced_pkg::EV_UP] = 1'b1;
          case (btn_state.mode)
            bced_pkg::MODE_IDLE: begin
              if (lvl) begin
                btn_state.timer = btn_cfg.hold_limit;
                btn_state.mode  = bced_pkg::MODE_PRESSED;
              end
            end
            bced_pkg::MODE_PRESSED: begin
              if (!lvl) begin
                btn_state.timer = btn_cfg.double_win;
                btn_state.mode  = bced_pkg::MODE_RELEASED;
              end else if (btn_state.timer == '0) begin
                btn_state.timer = btn_cfg.repeat_ticks;
                btn_state.events[bced_pkg::EV_LONG] = 1'b1;
                btn_state.mode  = bced_pkg::MODE_LONG;
              end
            end
            bced_pkg::MODE_RELEASED: begin
              if (lvl) begin
                btn_state.mode = bced_pkg::MODE_SECOND;
              end else if (btn_state.timer == '0) begin
                btn_state.events[bced_pkg::EV_SINGLE] = 1'b1;
                btn_state.mode = bced_pkg::MODE_IDLE;
              end
            end
            bced_pkg::MODE_SECOND: begin
              if (!lvl) begin
                btn_state.events[bced_pkg::EV_DOUBLE] = 1'b1;
                btn_state.mode = bced_pkg::MODE_IDLE;
              end
            end
            bced_pkg::MODE_LONG: begin
              btn_state.events[bced_pkg::EV_LONG] = 1'b1;
              if (!lvl) begin
                btn_state.mode = bced_pkg::MODE_IDLE;
              end else if (btn_state.timer == '0) begin
                btn_state.timer = btn_cfg.repeat_ticks;
                btn_state.events[bced_pkg::EV_REPEAT] = 1'b1;
              end
            end
            default: begin
              btn_state.mode = bced_pkg::MODE_IDLE;
            end
          endcase
          btn_state.last = lvl;
        end
      end
      bced_pkg::OP_CHECK: begin
        // A hold-only query peeks without clearing.
        r.matched = |(btn_state.events & mask);
        if (r.matched && mask != bced_pkg::EV_HOLD_ONLY) begin
          btn_state.events = btn_state.events & ~mask;
        end
      end
      bced_pkg::OP_CLEAR: begin
        btn_state.events = '0;
      end
      default: begin
      end
    endcase
    r.flags_now   = btn_state.events;
    r.pressed     = btn_state.events[bced_pkg::EV_HOLD];
    r.logic_level = lvl;
    return r;
  endfunction

  // Map a wanted key state onto the raw pin level under the current polarity.
  function automatic logic level_to_pin(logic down);
    return btn_cfg.press_low ? ~down : down;
  endfunction

  // Mix of the interesting masks and plain random ones.
  function automatic logic [bced_pkg::EV_W-1:0] pick_mask();
    case ($urandom_range(9))
      0: return bced_pkg::EV_HOLD_ONLY;
      1: return EV_ALL_MASK;
      2: return EV_NONE;
      default: return bced_pkg::EV_W'($urandom_range(127));
    endcase
  endfunction

  // Offer one item, hold it until accepted, then queue its prediction.
  task automatic send_item(logic [1:0] op, logic pin, logic [bced_pkg::EV_W-1:0] mask);
    int gap;
    gap = 0;
    while (gap < 24 && $urandom_range(99) < sender_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.operation  <= op;
    in_chan.pin_level  <= pin;
    in_chan.event_mask <= mask;
    do @(posedge clk); while (!in_chan.ready);
    pending_results.push_back(predict_click_result(op, pin, mask));
    items_sent++;
  endtask

  // Drop valid and wait until every queued item has come back.
  task automatic drain_results();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // One register write; only called while the block is idle.
  task automatic write_reg(logic [bced_pkg::CFG_IDX_W-1:0] idx,
                           logic [bced_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bced_pkg::CFG_POLARITY:   btn_cfg.press_low    = value[0];
      bced_pkg::CFG_DEBOUNCE:   btn_cfg.debounce     = value[bced_pkg::DIV_W-1:0];
      bced_pkg::CFG_HOLD_LIMIT: btn_cfg.hold_limit   = value[bced_pkg::TIMER_W-1:0];
      bced_pkg::CFG_DOUBLE_WIN: btn_cfg.double_win   = value[bced_pkg::TIMER_W-1:0];
      bced_pkg::CFG_REPEAT:     btn_cfg.repeat_ticks = value[bced_pkg::TIMER_W-1:0];
      default: begin
      end
    endcase
  endtask

  // Drain, then load all five registers. Polarity and debounce get random upper bits.
  task automatic apply_settings(logic al, logic [bced_pkg::DIV_W-1:0] deb,
                                logic [bced_pkg::TIMER_W-1:0] lp,
                                logic [bced_pkg::TIMER_W-1:0] dw,
                                logic [bced_pkg::TIMER_W-1:0] rp);
    drain_results();
    write_reg(bced_pkg::CFG_POLARITY,
              {(bced_pkg::CFG_W-1)'($urandom_range(32767)), al});
    write_reg(bced_pkg::CFG_DEBOUNCE,
              {(bced_pkg::CFG_W-bced_pkg::DIV_W)'($urandom_range(255)), deb});
    write_reg(bced_pkg::CFG_HOLD_LIMIT, lp);
    write_reg(bced_pkg::CFG_DOUBLE_WIN, dw);
    write_reg(bced_pkg::CFG_REPEAT, rp);
  endtask

  // Hold the key in one state for len ticks, with stray glitches and checks.
  task automatic send_level_run(logic down, int len);
    int   k;
    logic lvl;
    for (k = 0; k < len && items_sent < traffic_goal; k++) begin
      if ($urandom_range(99) < 8) begin
        send_item(bced_pkg::OP_CHECK, 1'($urandom_range(1)), pick_mask());
      end
      lvl = ($urandom_range(99) < 4) ? ~down : down;
      send_item(bced_pkg::OP_TICK, level_to_pin(lvl),
                bced_pkg::EV_W'($urandom_range(127)));
    end
  endtask

  // Mostly whole click gestures sized to the current timing; the rest is noise.
  task automatic run_click_traffic(int n_items);
    int unit;
    int press_span;
    int release_span;
    traffic_goal = items_sent + n_items;
    while (items_sent < traffic_goal) begin
      unit = int'(btn_cfg.debounce) + 1;
      press_span = int'(btn_cfg.hold_limit) + 3 * int'(btn_cfg.repeat_ticks) + 2 * unit;
      if (press_span > RUN_CAP) press_span = RUN_CAP;
      release_span = int'(btn_cfg.double_win) + 2 * unit;
      if (release_span > RUN_CAP) release_span = RUN_CAP;
      if ($urandom_range(99) < 80) begin
        send_level_run(1'b1, $urandom_range(1) ? $urandom_range(3 * unit, 1)
                                               : $urandom_range(press_span, 1));
        send_level_run(1'b0, $urandom_range(release_span, 1));
        // Follow up with a second press about half of the time.
        if ($urandom_range(1)) begin
          send_level_run(1'b1, $urandom_range(3 * unit, 1));
          send_level_run(1'b0, $urandom_range(release_span, 1));
        end
        if ($urandom_range(99) < 30) begin
          send_item(bced_pkg::OP_CHECK, 1'($urandom_range(1)), pick_mask());
        end
      end else begin
        send_item(2'($urandom_range(3)), 1'($urandom_range(1)),
                  bced_pkg::EV_W'($urandom_range(127)));
      end
    end
  endtask

  // Default registers straight after reset.
  task automatic test_reset_defaults();
    send_item(bced_pkg::OP_CHECK, 1'b1, EV_ALL_MASK);
    send_item(bced_pkg::OP_TICK, 1'b0, EV_NONE);
    send_item(OP_RESERVED, 1'b1, EV_ALL_MASK);
    send_item(bced_pkg::OP_CLEAR, 1'b0, EV_ALL_MASK);
  endtask

  // Zero debounce and zero timing: every gesture resolves on the next tick.
  task automatic test_zero_timing();
    apply_settings(1'b0, '0, '0, '0, '0);
    send_item(bced_pkg::OP_TICK, 1'b1, EV_NONE);    // idle -> pressed, hold and down
    send_item(bced_pkg::OP_TICK, 1'b1, EV_NONE);    // timer expired -> long hold
    send_item(bced_pkg::OP_TICK, 1'b1, EV_NONE);    // repeat fires at once
    send_item(bced_pkg::OP_CHECK, 1'b0, bced_pkg::EV_HOLD_ONLY);
    send_item(bced_pkg::OP_CHECK, 1'b0, EV_NONE);
    send_item(bced_pkg::OP_CHECK, 1'b0,
              bced_pkg::EV_W'((1 << bced_pkg::EV_LONG) | (1 << bced_pkg::EV_REPEAT)));
    send_item(bced_pkg::OP_TICK, 1'b0, EV_NONE);    // release from long hold
    send_item(bced_pkg::OP_TICK, 1'b1, EV_NONE);
    send_item(bced_pkg::OP_TICK, 1'b0, EV_NONE);    // released, window already empty
    send_item(bced_pkg::OP_TICK, 1'b0, EV_NONE);    // single click
    send_item(bced_pkg::OP_TICK, 1'b1, EV_NONE);
    send_item(bced_pkg::OP_TICK, 1'b0, EV_NONE);
    send_item(bced_pkg::OP_TICK, 1'b1, EV_NONE);    // second press inside the window
    send_item(bced_pkg::OP_TICK, 1'b0, EV_NONE);    // double click
    send_item(bced_pkg::OP_CHECK, 1'b1, EV_ALL_MASK);
    send_item(bced_pkg::OP_CLEAR, 1'b1, EV_NONE);
  endtask

  // Lower debounce below the divider count; the machine must run on the next tick.
  task automatic test_divider_catch_up();
    int k;
    apply_settings(1'b1, 8'd8, 16'd3, 16'd3, 16'd2);
    for (k = 0; k < 5; k++) send_item(bced_pkg::OP_TICK, 1'b0, EV_NONE);
    drain_results();
    write_reg(bced_pkg::CFG_DEBOUNCE,
              {(bced_pkg::CFG_W-bced_pkg::DIV_W)'($urandom_range(255)), 8'd2});
    send_item(bced_pkg::OP_TICK, 1'b0, EV_NONE);
    send_item(bced_pkg::OP_CHECK, 1'b0, EV_ALL_MASK);
  endtask

  // Writes to unmapped register indexes and the reserved operation change nothing.
  task automatic test_unused_codes();
    int idx;
    drain_results();
    for (idx = CFG_IDX_USED; idx < (1 << bced_pkg::CFG_IDX_W); idx++) begin
      write_reg(bced_pkg::CFG_IDX_W'(idx), bced_pkg::CFG_W'($urandom_range(16'hffff)));
    end
    send_item(OP_RESERVED, 1'b0, EV_NONE);
    send_item(bced_pkg::OP_CHECK, 1'b1, EV_ALL_MASK);
  endtask

  // Random gestures through every idling phase and the register extremes.
  task automatic test_random_clicks();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    apply_settings(1'b1, bced_pkg::RST_DEBOUNCE, bced_pkg::RST_HOLD_LIMIT,
                   bced_pkg::RST_DOUBLE_WIN, bced_pkg::RST_REPEAT);
    run_click_traffic(200);

    sender_idle_pct = 74;
    apply_settings(1'($urandom_range(1)), 8'($urandom_range(4)), 16'($urandom_range(40)),
                   16'($urandom_range(20)), 16'($urandom_range(12)));
    run_click_traffic(400);

    sender_idle_pct = 0;
    receiver_stall_pct = 74;
    apply_settings(1'($urandom_range(1)), 8'($urandom_range(4)), 16'($urandom_range(40)),
                   16'($urandom_range(20)), 16'($urandom_range(12)));
    run_click_traffic(400);

    // Smallest legal timing.
    sender_idle_pct = 11;
    receiver_stall_pct = 11;
    apply_settings(1'($urandom_range(1)), 8'd1, 16'd1, 16'd1, 16'd1);
    run_click_traffic(300);

    // Largest timing: at most one evaluation or so in this stretch.
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    apply_settings(1'($urandom_range(1)), '1, '1, '1, '1);
    run_click_traffic(150);

    sender_idle_pct = 11;
    receiver_stall_pct = 11;
    apply_settings(1'($urandom_range(1)), 8'($urandom_range(4)), 16'($urandom_range(40)),
                   16'($urandom_range(20)), 16'($urandom_range(12)));
    run_click_traffic(400);
  endtask

  // Hold the receiver off while the sender keeps offering, so the input stalls.
  task automatic test_backpressure();
    drain_results();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_off_left = 150;
    run_click_traffic(40);
  endtask

  // Receiver: drive ready at the falling edge, honoring any long hold-off.
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_chan.ready <= 1'b0;
      hold_off_left = hold_off_left - 1;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Compare every accepted result against the oldest prediction.
  always @(posedge clk) begin
    click_result_t seen;
    click_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      seen.matched     = out_chan.matched;
      seen.flags_now   = out_chan.flags_now;
      seen.pressed     = out_chan.pressed;
      seen.logic_level = out_chan.logic_level;
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS) begin
          $display("unexpected result: matched=%0b flags=%h pressed=%0b level=%0b",
                   seen.matched, seen.flags_now, seen.pressed, seen.logic_level);
        end
      end else begin
        want = pending_results.pop_front();
        if (seen.matched !== want.matched || seen.flags_now !== want.flags_now ||
            seen.pressed !== want.pressed || seen.logic_level !== want.logic_level) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS) begin
            $display("mismatch: expected matched=%0b flags=%h pressed=%0b level=%0b",
                     want.matched, want.flags_now, want.pressed, want.logic_level);
            $display("          actual   matched=%0b flags=%h pressed=%0b level=%0b",
                     seen.matched, seen.flags_now, seen.pressed, seen.logic_level);
          end
        end
      end
    end
  end

  initial begin
    // Known values on every input from time zero; reset mirrors the block's defaults.
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    in_chan.valid      = 1'b0;
    in_chan.operation  = bced_pkg::OP_TICK;
    in_chan.pin_level  = 1'b0;
    in_chan.event_mask = EV_NONE;
    out_chan.ready     = 1'b0;
    btn_cfg = '{press_low: 1'b1, debounce: bced_pkg::RST_DEBOUNCE,
                hold_limit: bced_pkg::RST_HOLD_LIMIT,
                double_win: bced_pkg::RST_DOUBLE_WIN,
                repeat_ticks: bced_pkg::RST_REPEAT};
    btn_state = '{mode: bced_pkg::MODE_IDLE, timer: '0, div: '0, last: 1'b0, events: '0};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_zero_timing();
    test_divider_catch_up();
    test_unused_codes();
    test_random_clicks();
    test_backpressure();

    // Let the pipeline empty and give stray results a chance to show.
    drain_results();
    repeat (4) @(posedge clk);
    if (fault_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
